@@ rtl/trd_pkg.sv @@
// ============================================================================
// trd_pkg - shared types and constants of the TGA RLE pixel decoder
// Holds the decoded pixel record that passes from the front end through the
// queue to the output stage, plus register indexes and reset values.
// ============================================================================
package trd_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_TOTAL     = 2'd1;

    localparam logic [2:0]  BPP_RESET       = 3'd3;
    localparam logic [2:0]  BPP_RGBA        = 3'd4;
    localparam logic [31:0] PIXEL_TOTAL_RST = 32'd1;

    // Run packet header holds repeat count plus this bias
    localparam logic [7:0] RUN_BIAS = 8'd127;

    typedef struct packed {
        logic [7:0] run_length;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last_pixel;
        logic       overrun_error;
    } pix_rec_t;

endpackage

@@ rtl/trd_front.sv @@
// ============================================================================
// trd_front - byte parser of the TGA RLE pixel decoder
// Accepts one coded byte per cycle unless the queue is full, tracks headers
// and pixel bytes, counts pixels against the total, pushes a record per pixel.
// ============================================================================
module trd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic [2:0]        bytes_per_pixel,
    input  logic [31:0]       pixel_total,
    output logic              push,
    output trd_pkg::pix_rec_t push_rec,
    input  logic              queue_full
);

    typedef enum logic {
        PH_HEADER,
        PH_PIXEL
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        is_run_reg, is_run_next;
    logic [7:0]  left_reg, left_next;
    logic [1:0]  bip_reg, bip_next;
    logic [31:0] done_reg, done_next;
    logic [7:0]  pb_reg [4];
    logic [7:0]  pb_next [4];

    logic        accept;
    logic [2:0]  size_w;
    logic [2:0]  bip_inc;
    logic        complete;
    logic [7:0]  count;
    logic [32:0] total;
    logic        err;
    logic        last;
    logic [7:0]  left_dec;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign size_w   = (bytes_per_pixel == trd_pkg::BPP_RGBA) ? 3'd4 : 3'd3;
    assign bip_inc  = {1'b0, bip_reg} + 3'd1;
    assign complete = !(bip_inc < size_w);
    assign count    = is_run_reg ? left_reg : 8'd1;
    assign total    = {1'b0, done_reg} + {25'd0, count};
    assign err      = total > {1'b0, pixel_total};
    assign left_dec = is_run_reg ? 8'd0 : (left_reg - 8'd1);
    assign last     = !err && (left_dec == 8'd0) && (total[31:0] == pixel_total);

    always_comb begin
        pb_next          = pb_reg;
        pb_next[bip_reg] = in_byte;
    end

    always_comb begin
        push_rec.red           = pb_next[2];
        push_rec.green         = pb_next[1];
        push_rec.blue          = pb_next[0];
        push_rec.alpha         = (size_w == 3'd4) ? pb_next[3] : 8'd0;
        push_rec.run_length    = err ? 8'd0 : count;
        push_rec.last_pixel    = last;
        push_rec.overrun_error = err;
    end

    assign push = accept && (phase_reg == PH_PIXEL) && complete;

    always_comb begin
        phase_next  = phase_reg;
        is_run_next = is_run_reg;
        left_next   = left_reg;
        bip_next    = bip_reg;
        done_next   = done_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HEADER: begin
                    is_run_next = in_byte[7];
                    left_next   = in_byte[7] ? (in_byte - trd_pkg::RUN_BIAS)
                                             : (in_byte + 8'd1);
                    bip_next    = 2'd0;
                    phase_next  = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if (!complete) begin
                        bip_next = bip_inc[1:0];
                    end else begin
                        bip_next = 2'd0;
                        if (err || last) begin
                            // restart the image
                            phase_next  = PH_HEADER;
                            is_run_next = 1'b0;
                            left_next   = 8'd0;
                            done_next   = 32'd0;
                        end else begin
                            done_next = total[31:0];
                            left_next = left_dec;
                            if (left_dec == 8'd0) begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
                default: phase_next = PH_HEADER;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            is_run_reg <= 1'b0;
            left_reg   <= 8'd0;
            bip_reg    <= 2'd0;
            done_reg   <= 32'd0;
        end else begin
            phase_reg  <= phase_next;
            is_run_reg <= is_run_next;
            left_reg   <= left_next;
            bip_reg    <= bip_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (phase_reg == PH_PIXEL)) begin
            pb_reg <= pb_next;
        end
    end

`ifndef SYNTHESIS
    a_err_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_rec.overrun_error |=> phase_reg == PH_HEADER && done_reg == 32'd0)
        else $error("overrun did not restart the image");

    a_header_enters_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && phase_reg == PH_HEADER |=> phase_reg == PH_PIXEL && bip_reg == 2'd0
            && left_reg != 8'd0)
        else $error("header did not open a packet");

    a_done_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !push_rec.overrun_error |-> total <= {1'b0, pixel_total})
        else $error("pixel count passed the image total");
`endif

endmodule

@@ rtl/trd_fifo.sv @@
// ============================================================================
// trd_fifo - two-entry record queue
// Decouples the byte parser from the output stage so either side can stall.
// ============================================================================
module trd_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  trd_pkg::pix_rec_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output trd_pkg::pix_rec_t rd_data
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    trd_pkg::pix_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !wr_en)
        else $error("write into a full queue");
`endif

endmodule

@@ rtl/trd_back.sv @@
// ============================================================================
// trd_back - output stage of the TGA RLE pixel decoder
// Pulls records from the queue into the output register and presents them
// on the result stream until taken.
// ============================================================================
module trd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  trd_pkg::pix_rec_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output trd_pkg::pix_rec_t out_rec
);

    logic              valid_reg, valid_next;
    trd_pkg::pix_rec_t rec_reg;
    logic              load;

    // refill when the register is empty or its beat is being taken
    assign load       = !valid_reg || out_ready;
    assign q_pop      = load && q_valid;
    assign valid_next = load ? q_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_rec    = rec_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rec_reg <= q_data;
        end
    end

`ifndef SYNTHESIS
    a_fill_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg && q_valid |=> valid_reg)
        else $error("output register not refilled from queue");
`endif

endmodule

@@ rtl/tga_rle_pixel_decoder_core.sv @@
// ============================================================================
// tga_rle_pixel_decoder_core - run-length TGA truecolor pixel decoder
// Decodes RLE TGA pixel data, one byte per beat, into RGBA pixel beats.
// ============================================================================
// Usage:
//   s_* stream carries the coded pixel bytes, one byte per beat. Every byte is
//   a packet header or a stored pixel byte; headers give no output.
//   m_* stream carries one beat per stored pixel: a raw pixel with run length
//   1, or a run pixel once with its repeat count. m_tlast marks the beat that
//   completes the image; m_tuser flags an overrun (run length 0), after which
//   the decoder starts a new image. The same happens after the last pixel.
//   cfg_* writes bytes_per_pixel (index 0) and pixel_total (index 1); write
//   only while the decoder is idle. cfg_ready is always high.
// Timing:
//   One byte is accepted every cycle while the queue is not full. A pixel
//   beat passes through the queue and then the output register before it
//   appears on m_*. The two-entry queue plus the output register absorb a
//   stalled receiver; s_tready drops only once the queue is full. The
//   parser's 33-bit count add and compare set the clock.
// Reset: aresetn low (synchronous) empties the pipeline, restarts the image
//   and loads bytes_per_pixel = 3 and pixel_total = 1.
// ============================================================================
module tga_rle_pixel_decoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: [7:0] in_byte
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    // m_tdata: [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
    //          [39:32] run_length
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,
    output logic                             m_tlast,
    // m_tuser: [0] overrun_error
    output logic [0:0]                       m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [trd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [2:0]        bpp_reg;
    logic [31:0]       total_reg;
    logic              push;
    trd_pkg::pix_rec_t push_rec;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    trd_pkg::pix_rec_t q_data;
    trd_pkg::pix_rec_t out_rec;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpp_reg   <= trd_pkg::BPP_RESET;
            total_reg <= trd_pkg::PIXEL_TOTAL_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                trd_pkg::REG_BYTES_PER_PIXEL: bpp_reg   <= cfg_data[2:0];
                trd_pkg::REG_PIXEL_TOTAL:     total_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    trd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_byte         (s_tdata),
        .bytes_per_pixel (bpp_reg),
        .pixel_total     (total_reg),
        .push            (push),
        .push_rec        (push_rec),
        .queue_full      (q_full)
    );

    trd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (push),
        .wr_data  (push_rec),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    trd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (out_rec)
    );

    assign m_tdata = {out_rec.run_length, out_rec.alpha, out_rec.blue,
                      out_rec.green, out_rec.red};
    assign m_tlast    = out_rec.last_pixel;
    assign m_tuser[0] = out_rec.overrun_error;

endmodule
